/* hw/rtl/bth_pkg.sv */
// ----------------------------------------------------------------------------
// bth_pkg
// Types, constants and helpers shared by the bounded top-k store.
// ----------------------------------------------------------------------------
package bth_pkg;

  localparam int CFG_W     = 7;
  localparam int CNT_OUT_W = 7;
  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] item_id;
    logic [31:0] score;
  } bth_in_t;

  typedef struct packed {
    logic                 accepted;
    logic                 entry_valid;
    logic [15:0]          entry_id;
    logic [31:0]          entry_score;
    logic [CNT_OUT_W-1:0] count_held;
    logic                 last;
  } bth_out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] score;
  } bth_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_MOVE,
    S_EMIT
  } bth_state_t;

  typedef struct packed {
    logic latch_in;
    logic push_append;
    logic empty_result;
    logic scan_start;
    logic scan_rd;
    logic decide_push;
    logic decide_drain;
    logic move_wr;
    logic load_out;
  } bth_cmd_t;

  typedef struct packed {
    logic kind;
    logic room;
    logic cnt_zero;
    logic scan_last;
    logic out_free;
    logic res_last;
  } bth_sts_t;

  // order: score ascending, then id ascending
  function automatic logic entry_less(bth_entry_t a, bth_entry_t b);
    entry_less = (a.score < b.score) || ((a.score == b.score) && (a.id < b.id));
  endfunction

endpackage

/* hw/rtl/bounded_top_k_heap.sv */
// ----------------------------------------------------------------------------
// bounded_top_k_heap
// Bounded store of the best-scoring items with eviction of the least entry.
// ----------------------------------------------------------------------------
// A push appends directly while the store has room. Once the store is
// full, a push scans the held entries for the least one (score, then id),
// one entry per cycle through the single read port of the entry memory. A
// drain returns the entries in ascending order; each one costs a full scan
// of the entries still held plus the move of the top entry into the freed
// slot. Results wait in an output register; a new request is taken once
// the previous one has placed its last result there. No clearing pass is
// needed after reset.
module bounded_top_k_heap
  import bth_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bth_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bth_out_t         out_data,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  bth_cmd_t cmd;
  bth_sts_t sts;

  bth_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bth_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

/* hw/rtl/bth_ram.sv */
// ----------------------------------------------------------------------------
// bth_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bth_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/bth_ctrl.sv */
// ----------------------------------------------------------------------------
// bth_ctrl
// Sequencer for push, scan for least entry, evict and drain.
// ----------------------------------------------------------------------------
module bth_ctrl
  import bth_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bth_sts_t sts,
  output bth_cmd_t cmd
);

  bth_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_START;
      end
      S_START: begin
        if (sts.kind == KIND_PUSH) begin
          state_nxt = sts.room ? S_EMIT : S_SCAN;
        end else begin
          state_nxt = sts.cnt_zero ? S_EMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_last) state_nxt = S_SCAN_END;
      end
      S_SCAN_END: state_nxt = S_DECIDE;
      S_DECIDE: begin
        state_nxt = (sts.kind == KIND_PUSH) ? S_EMIT : S_MOVE;
      end
      S_MOVE: state_nxt = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) state_nxt = sts.res_last ? S_IDLE : S_SCAN;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      S_START: begin
        if (sts.kind == KIND_PUSH) begin
          cmd.push_append = sts.room;
          cmd.scan_start  = !sts.room;
        end else begin
          cmd.empty_result = sts.cnt_zero;
          cmd.scan_start   = !sts.cnt_zero;
        end
      end
      S_SCAN: cmd.scan_rd = 1'b1;
      S_DECIDE: begin
        cmd.decide_push  = (sts.kind == KIND_PUSH);
        cmd.decide_drain = (sts.kind == KIND_DRAIN);
      end
      S_MOVE: cmd.move_wr = 1'b1;
      S_EMIT: begin
        cmd.load_out   = sts.out_free;
        cmd.scan_start = sts.out_free && !sts.res_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* hw/rtl/bth_dp.sv */
// ----------------------------------------------------------------------------
// bth_dp
// Entry store, least-entry scan, result register and output register.
// ----------------------------------------------------------------------------
module bth_dp
  import bth_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bth_in_t          in_data,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             out_ready,
  output logic             out_valid,
  output bth_out_t         out_data,
  input  bth_cmd_t         cmd,
  output bth_sts_t         sts
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > CFG_W) ? CW : CFG_W;

  bth_in_t          in_r;
  logic [CFG_W-1:0] cap_r;
  logic [CW-1:0]    count_r;
  logic [AW-1:0]    idx_r;
  logic             rd_pend_r;
  logic [AW-1:0]    rd_slot_r;
  bth_entry_t       best_r;
  logic [AW-1:0]    best_slot_r;
  bth_out_t         res_r;
  logic             out_valid_r;
  bth_out_t         out_data_r;

  logic [EW-1:0]    cap_e, max_e, eff_cap;
  logic [AW-1:0]    top_addr;
  bth_entry_t       rd_entry, new_entry;
  logic             win;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_wa, ram_ra;
  bth_entry_t       ram_wd;

  // effective capacity: zero reads as one, saturates at CAPACITY
  assign cap_e   = EW'(cap_r);
  assign max_e   = EW'(CAPACITY);
  assign eff_cap = (cap_r == '0) ? EW'(1) : ((cap_e > max_e) ? max_e : cap_e);

  assign top_addr  = AW'(count_r - CW'(1));
  assign new_entry = '{id: in_r.item_id, score: in_r.score};
  assign win       = in_r.score > best_r.score;

  assign ram_we = cmd.push_append | (cmd.decide_push & win) | cmd.move_wr;
  assign ram_wa = cmd.push_append ? AW'(count_r) : best_slot_r;
  assign ram_wd = cmd.move_wr ? rd_entry : new_entry;
  assign ram_re = cmd.scan_rd | cmd.decide_drain;
  assign ram_ra = cmd.scan_rd ? idx_r : top_addr;

  bth_ram #(
    .WIDTH($bits(bth_entry_t)),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      if (cmd.push_append) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.decide_drain) begin
        count_r <= count_r - CW'(1);
      end
      rd_pend_r <= cmd.scan_rd;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) in_r <= in_data;
    if (cmd.scan_start) begin
      idx_r <= '0;
    end else if (cmd.scan_rd) begin
      idx_r <= idx_r + AW'(1);
    end
    rd_slot_r <= idx_r;
    // strict compare keeps the lower slot on a full tie
    if (rd_pend_r && ((rd_slot_r == '0) || entry_less(rd_entry, best_r))) begin
      best_r      <= rd_entry;
      best_slot_r <= rd_slot_r;
    end
    if (cmd.push_append) begin
      res_r <= '{accepted: 1'b1, entry_valid: 1'b0, entry_id: '0, entry_score: '0,
                 count_held: CNT_OUT_W'(count_r + CW'(1)), last: 1'b1};
    end else if (cmd.empty_result) begin
      res_r <= '{accepted: 1'b0, entry_valid: 1'b0, entry_id: '0, entry_score: '0,
                 count_held: '0, last: 1'b1};
    end else if (cmd.decide_push) begin
      res_r <= '{accepted: win, entry_valid: win,
                 entry_id: win ? best_r.id : '0,
                 entry_score: win ? best_r.score : '0,
                 count_held: CNT_OUT_W'(count_r), last: 1'b1};
    end else if (cmd.decide_drain) begin
      res_r <= '{accepted: 1'b0, entry_valid: 1'b1, entry_id: best_r.id,
                 entry_score: best_r.score,
                 count_held: CNT_OUT_W'(count_r - CW'(1)),
                 last: (count_r == CW'(1))};
    end
    if (cmd.load_out) out_data_r <= res_r;
  end

  assign sts.kind      = in_r.kind;
  assign sts.room      = EW'(count_r) < eff_cap;
  assign sts.cnt_zero  = (count_r == '0);
  assign sts.scan_last = (idx_r == top_addr);
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.res_last  = res_r.last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* bench/bounded_top_k_heap_tb.sv */
// ----------------------------------------------------------------------------
// bounded_top_k_heap_tb
// Self-checking bench for the bounded top-k store. Requests are queued by a
// directed part and several random phases at different capacities, driven
// with random gaps outside the back-to-back phase, and every result is
// checked field by field against a slot-for-slot store model in the bench.
// ----------------------------------------------------------------------------
module bounded_top_k_heap_tb
  import bth_pkg::*;
;

  localparam int CAP = 64;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  bth_in_t          in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  bth_out_t         out_data;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  // bench copy of the store
  logic [15:0]      kept_id [CAP];
  logic [31:0]      kept_score [CAP];
  int               kept_count = 0;
  logic [CFG_W-1:0] cap_reg = CAP_RESET;

  bth_in_t  requests_waiting [$];
  bth_out_t results_due [$];

  logic        no_idle = 1'b0;
  logic        stall_phase = 1'b0;
  int          stall_cycles = 0;
  int unsigned errors = 0;
  int unsigned n_requests = 0;
  int unsigned n_results = 0;
  int unsigned n_evictions = 0;
  int unsigned n_drained = 0;

  bounded_top_k_heap #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  // least entry: score, then id, then lowest slot
  function automatic int lowest_slot();
    int best;
    best = 0;
    for (int i = 1; i < kept_count; i++) begin
      if (kept_score[i] < kept_score[best] ||
          (kept_score[i] == kept_score[best] && kept_id[i] < kept_id[best]))
        best = i;
    end
    return best;
  endfunction

  task automatic predict_request(input bth_in_t rq);
    int       cap;
    int       s;
    int       top;
    bth_out_t r;
    cap = (cap_reg == 0) ? 1 : ((cap_reg > CAP) ? CAP : int'(cap_reg));
    r = '0;
    r.last = 1'b1;
    if (rq.kind == KIND_PUSH) begin
      if (kept_count < cap) begin
        kept_id[kept_count] = rq.item_id;
        kept_score[kept_count] = rq.score;
        kept_count++;
        r.accepted = 1'b1;
      end else begin
        // full (or capacity lowered below count): only the least may go
        s = lowest_slot();
        if (rq.score > kept_score[s]) begin
          r.accepted = 1'b1;
          r.entry_valid = 1'b1;
          r.entry_id = kept_id[s];
          r.entry_score = kept_score[s];
          kept_id[s] = rq.item_id;
          kept_score[s] = rq.score;
        end
      end
      r.count_held = CNT_OUT_W'(kept_count);
      results_due.insert(results_due.size(), r);
    end else if (kept_count == 0) begin
      results_due.insert(results_due.size(), r);
    end else begin
      while (kept_count > 0) begin
        s = lowest_slot();
        top = kept_count - 1;
        r.entry_valid = 1'b1;
        r.entry_id = kept_id[s];
        r.entry_score = kept_score[s];
        kept_id[s] = kept_id[top];
        kept_score[s] = kept_score[top];
        kept_count = top;
        r.count_held = CNT_OUT_W'(top);
        r.last = (top == 0);
        results_due.insert(results_due.size(), r);
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(in_data);
        n_requests++;
      end
      if (!in_valid || in_ready) begin
        if (requests_waiting.size() != 0 && (no_idle || $urandom_range(99) >= 23)) begin
          in_valid <= 1'b1;
          in_data <= requests_waiting.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver hold-off, once, at the start of the stall phase
  always @(posedge clk) begin
    if (stall_phase && stall_cycles < HOLDOFF_CYCLES)
      stall_cycles <= stall_cycles + 1;
  end

  // monitor
  always @(posedge clk) begin
    bth_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (out_data.entry_valid && out_data.accepted)
          n_evictions++;
        if (out_data.entry_valid && !out_data.accepted)
          n_drained++;
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result at %0t: id=%h score=%h cnt=%0d",
                     $time, out_data.entry_id, out_data.entry_score,
                     out_data.count_held);
        end else begin
          want = results_due.pop_front();
          if (out_data.accepted !== want.accepted ||
              out_data.entry_valid !== want.entry_valid ||
              out_data.entry_id !== want.entry_id ||
              out_data.entry_score !== want.entry_score ||
              out_data.count_held !== want.count_held ||
              out_data.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at %0t: exp acc=%0b ev=%0b id=%h sc=%h cnt=%0d last=%0b",
                       $time, want.accepted, want.entry_valid, want.entry_id,
                       want.entry_score, want.count_held, want.last);
              $display("                 got acc=%0b ev=%0b id=%h sc=%h cnt=%0d last=%0b",
                       out_data.accepted, out_data.entry_valid, out_data.entry_id,
                       out_data.entry_score, out_data.count_held, out_data.last);
            end
          end
        end
      end
      out_ready <= !(stall_phase && stall_cycles < HOLDOFF_CYCLES) &&
                   (no_idle || $urandom_range(99) >= 23);
    end
  end

  task automatic add_request(input logic kind, input logic [15:0] id,
                             input logic [31:0] score);
    bth_in_t rq;
    rq.kind = kind;
    rq.item_id = id;
    rq.score = score;
    requests_waiting.insert(requests_waiting.size(), rq);
  endtask

  function automatic bth_in_t random_request(int drain_pct);
    bth_in_t rq;
    int      pick;
    rq.kind = ($urandom_range(99) < drain_pct) ? KIND_DRAIN : KIND_PUSH;
    rq.item_id = ($urandom_range(1) != 0) ? 16'($urandom_range(0, 7))
                                          : 16'($urandom_range(0, 65535));
    pick = $urandom_range(99);
    // a small score pool makes ties and equal-to-least rejections common
    if (pick < 35)
      rq.score = 32'($urandom_range(0, 7)) << 16;
    else if (pick < 45)
      rq.score = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    else
      rq.score = $urandom;
    return rq;
  endfunction

  task automatic wait_all_done();
    do
      @(negedge clk);
    while (requests_waiting.size() != 0 || in_valid || results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CFG_W-1:0] v);
    wait_all_done();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = v;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] cap, input int n, input int drain_pct);
    set_capacity(cap);
    @(negedge clk);
    for (int i = 0; i < n; i++)
      requests_waiting.insert(requests_waiting.size(), random_request(drain_pct));
    wait_all_done();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset capacity: empty drain, field extremes, ties, ordered drain
    @(negedge clk);
    add_request(KIND_DRAIN, 16'hFFFF, 32'hFFFF_FFFF);
    add_request(KIND_PUSH, 16'h0000, 32'h0000_0000);
    add_request(KIND_PUSH, 16'hFFFF, 32'hFFFF_FFFF);
    add_request(KIND_PUSH, 16'h5555, 32'h5555_5555);
    add_request(KIND_PUSH, 16'hAAAA, 32'hAAAA_AAAA);
    add_request(KIND_PUSH, 16'h0003, 32'h5555_5555);
    add_request(KIND_PUSH, 16'h0003, 32'h5555_5555);
    add_request(KIND_DRAIN, 16'h0000, 32'h0000_0000);
    wait_all_done();

    // zero capacity behaves as one
    set_capacity(7'd0);
    @(negedge clk);
    add_request(KIND_PUSH, 16'h0010, 32'h000A_0000);
    add_request(KIND_PUSH, 16'h0001, 32'h000A_0000);
    add_request(KIND_PUSH, 16'h0002, 32'h0005_0000);
    add_request(KIND_PUSH, 16'h0011, 32'h000B_0000);
    add_request(KIND_DRAIN, 16'h1234, 32'h1234_5678);
    wait_all_done();

    // fill three, then lower the capacity below the count held
    set_capacity(7'd3);
    @(negedge clk);
    add_request(KIND_PUSH, 16'h0007, 32'h0002_0000);
    add_request(KIND_PUSH, 16'h0004, 32'h0002_0000);
    add_request(KIND_PUSH, 16'h0009, 32'h0008_0000);
    add_request(KIND_PUSH, 16'h0000, 32'h0002_0000);
    set_capacity(7'd1);
    @(negedge clk);
    add_request(KIND_PUSH, 16'h0020, 32'h0003_0000);
    add_request(KIND_PUSH, 16'h0021, 32'h0001_0000);
    add_request(KIND_DRAIN, 16'h0000, 32'h0000_0000);
    wait_all_done();

    // register above the parameter saturates; receiver stalls early on
    set_capacity(7'd127);
    @(negedge clk);
    stall_phase = 1'b1;
    for (int i = 0; i < 70; i++)
      requests_waiting.insert(requests_waiting.size(), random_request(1));
    wait_all_done();
    stall_phase = 1'b0;

    run_phase(7'd5, 40, 8);
    run_phase(7'd1, 30, 10);
    no_idle = 1'b1;
    run_phase(7'd64, 60, 2);
    no_idle = 1'b0;
    run_phase(7'd100, 50, 2);
    run_phase(7'd33, 50, 4);
    @(negedge clk);
    add_request(KIND_DRAIN, 16'hFFFF, 32'h0000_0000);
    wait_all_done();

    repeat (20) @(posedge clk);
    if (results_due.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", results_due.size());
    end
    $display("covered %0d requests, %0d results checked (%0d evictions, %0d drained entries)",
             n_requests, n_results, n_evictions, n_drained);
    $display("capacities 0, 1, 3, 5, 33, 64, 100, 127; %0d errors", errors);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* bounded_top_k_heap.f */
hw/rtl/bth_pkg.sv
hw/rtl/bth_ram.sv
hw/rtl/bth_ctrl.sv
hw/rtl/bth_dp.sv
hw/rtl/bounded_top_k_heap.sv
bench/bounded_top_k_heap_tb.sv
